FILE: rtl/b58_pkg.sv
// base58 encoder package: size defaults, divide-by-58 constants, control struct
// and the digit-to-ASCII alphabet function
// no dependencies
`default_nettype none

package b58_pkg;

    localparam int MAX_BYTES_DEF = 40;
    localparam int MAX_CHARS_DEF = 55;

    localparam logic [6:0] CHAR_ONE = 7'h31;

    // floor(x / 58) = (x * DIV_RECIP) >> DIV_SHIFT, exact for x < 58 * 256
    localparam logic [14:0] DIV_RECIP = 15'd18080;
    localparam int          DIV_SHIFT = 20;

    typedef struct packed {
        logic clr;
        logic en;
    } div_ctrl_t;

    function automatic logic [6:0] b58_char(input logic [5:0] d);
        logic [6:0] c;
        c = 7'h30;
        case (d) inside
            [6'd0:6'd8]:   c = 7'h31 + 7'(d);
            [6'd9:6'd16]:  c = 7'h41 + 7'(d) - 7'd9;
            [6'd17:6'd21]: c = 7'h4a + 7'(d) - 7'd17;
            [6'd22:6'd32]: c = 7'h50 + 7'(d) - 7'd22;
            [6'd33:6'd43]: c = 7'h61 + 7'(d) - 7'd33;
            [6'd44:6'd57]: c = 7'h6d + 7'(d) - 7'd44;
            default:       c = 7'h30;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/b58_div_unit.sv
// shared long-division step: one byte of (rem * 256 + byte) / 58 per cycle while ctrl.en is set
// holds the running remainder; uses b58_pkg
`default_nettype none

module b58_div_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  b58_pkg::div_ctrl_t ctrl,
    input  logic [7:0]        din,
    output logic [7:0]        quo,
    output logic [5:0]        rem
);
    import b58_pkg::*;

    logic [5:0]  rem_reg;
    logic [5:0]  rem_next;
    logic [13:0] acc;
    logic [28:0] prod;
    logic [13:0] qx58;
    logic [13:0] diff;

    assign acc  = {rem_reg, din};
    assign prod = {15'd0, acc} * {14'd0, DIV_RECIP};
    assign quo  = prod[DIV_SHIFT +: 8];
    // q * 58 = q * 64 - q * 8 + q * 2
    assign qx58 = {quo, 6'b0} - {3'b0, quo, 3'b0} + {5'b0, quo, 1'b0};
    assign diff = acc - qx58;
    assign rem  = diff[5:0];

    always_comb
    begin
        rem_next = rem_reg;
        if (ctrl.clr)
        begin
            rem_next = 6'd0;
        end
        else if (ctrl.en)
        begin
            rem_next = rem;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= 6'd0;
        end
        else
        begin
            rem_reg <= rem_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/base58_encoder.sv
// base58 encoder top level: message and digit memories, sequencer, result register
// depends on b58_pkg and b58_div_unit
//
// channel  | ports                          | handshake
// ---------+--------------------------------+----------------------------------
// input    | data_byte, last_byte           | taken when start && !busy
// result   | out_char, last_char, overflow  | one cycle, marked by strobe
//
// a byte that is not the last is taken and busy stays low
// after the last of n bytes with z leading zeros, the shared divide-by-58 unit runs
// passes over the bytes left, one digit per pass, then comes a setup state and
// the characters in order, busy high until the final character
// an overlong message gives its single overflow result without going busy
// results cannot be stalled; reset needs no clearing pass
`default_nettype none

module base58_encoder #(
    parameter int MAX_BYTES = b58_pkg::MAX_BYTES_DEF,
    parameter int MAX_CHARS = b58_pkg::MAX_CHARS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       strobe,
    output logic [6:0] out_char,
    output logic       last_char,
    output logic       overflow
);
    import b58_pkg::*;

    localparam int CW  = $clog2(MAX_BYTES + 1);
    localparam int AW  = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int DCW = $clog2(MAX_CHARS + 1);
    localparam int DAW = $clog2(MAX_CHARS);
    localparam int TW  = ((CW > DCW) ? CW : DCW) + 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_PREP = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]     state_reg, state_next;
    logic [CW-1:0]  byte_cnt_reg, byte_cnt_next;
    logic [CW-1:0]  zero_run_reg, zero_run_next;
    logic           in_zero_reg, in_zero_next;
    logic           ovf_seen_reg, ovf_seen_next;
    logic [CW-1:0]  idx_reg, idx_next;
    logic           pend_reg, pend_next;
    logic           seen_nz_reg, seen_nz_next;
    logic [CW-1:0]  nstart_reg, nstart_next;
    logic [DCW-1:0] digit_cnt_reg, digit_cnt_next;
    logic [DCW-1:0] k_reg, k_next;
    logic           strobe_reg, strobe_next;
    logic [6:0]     out_char_reg, out_char_next;
    logic           last_char_reg, last_char_next;
    logic           overflow_reg, overflow_next;

    logic [7:0]     msg_mem [MAX_BYTES];
    logic [7:0]     msg_rd_reg;
    logic           msg_we, msg_re;
    logic [AW-1:0]  msg_waddr;
    logic [7:0]     msg_wdata;

    logic [5:0]     dig_mem [MAX_CHARS];
    logic [5:0]     dig_rd_reg;
    logic           dig_we, dig_re;
    logic [DAW-1:0] dig_waddr, dig_raddr;

    div_ctrl_t      div_ctrl;
    logic [7:0]     quo;
    logic [5:0]     rem;

    logic           accept;
    logic [CW-1:0]  bc_new, zr_new, proc_idx, nstart_fin;
    logic           iz_new, ovf_new;
    logic [TW-1:0]  tot, tot_cap, kr_ext, raddr_full;
    logic [DCW-1:0] kr;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    b58_div_unit u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .din   (msg_rd_reg),
        .quo   (quo),
        .rem   (rem)
    );

    assign proc_idx   = idx_reg - 1'b1;
    assign nstart_fin = (!seen_nz_reg && quo == 8'd0) ? idx_reg : nstart_reg;

    assign tot        = TW'(zero_run_reg) + TW'(digit_cnt_reg);
    assign tot_cap    = (tot > TW'(MAX_CHARS)) ? TW'(MAX_CHARS) : tot;
    assign kr         = (state_reg == ST_EMIT) ? k_reg + 1'b1 : k_reg;
    assign kr_ext     = TW'(kr);
    assign raddr_full = tot - 1'b1 - kr_ext;
    assign dig_raddr  = raddr_full[DAW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        byte_cnt_next  = byte_cnt_reg;
        zero_run_next  = zero_run_reg;
        in_zero_next   = in_zero_reg;
        ovf_seen_next  = ovf_seen_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        seen_nz_next   = seen_nz_reg;
        nstart_next    = nstart_reg;
        digit_cnt_next = digit_cnt_reg;
        k_next         = k_reg;
        strobe_next    = 1'b0;
        out_char_next  = 7'd0;
        last_char_next = 1'b0;
        overflow_next  = 1'b0;
        msg_we         = 1'b0;
        msg_re         = 1'b0;
        msg_waddr      = byte_cnt_reg[AW-1:0];
        msg_wdata      = data_byte;
        dig_we         = 1'b0;
        dig_re         = 1'b0;
        dig_waddr      = digit_cnt_reg[DAW-1:0];
        div_ctrl       = '0;
        bc_new         = byte_cnt_reg;
        zr_new         = zero_run_reg;
        iz_new         = in_zero_reg;
        ovf_new        = ovf_seen_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!ovf_seen_reg)
                    begin
                        if (byte_cnt_reg < CW'(MAX_BYTES))
                        begin
                            msg_we = 1'b1;
                            bc_new = byte_cnt_reg + 1'b1;
                            if (in_zero_reg && data_byte == 8'd0)
                            begin
                                zr_new = zero_run_reg + 1'b1;
                            end
                            else
                            begin
                                iz_new = 1'b0;
                            end
                        end
                        else
                        begin
                            ovf_new = 1'b1;
                        end
                    end
                    byte_cnt_next = bc_new;
                    zero_run_next = zr_new;
                    in_zero_next  = iz_new;
                    ovf_seen_next = ovf_new;
                    if (last_byte)
                    begin
                        if (ovf_new)
                        begin
                            strobe_next    = 1'b1;
                            last_char_next = 1'b1;
                            overflow_next  = 1'b1;
                            byte_cnt_next  = '0;
                            zero_run_next  = '0;
                            in_zero_next   = 1'b1;
                            ovf_seen_next  = 1'b0;
                        end
                        else
                        begin
                            digit_cnt_next = '0;
                            idx_next       = zr_new;
                            nstart_next    = zr_new;
                            pend_next      = 1'b0;
                            seen_nz_next   = 1'b0;
                            k_next         = '0;
                            div_ctrl.clr   = 1'b1;
                            state_next     = (zr_new < bc_new) ? ST_DIV : ST_PREP;
                        end
                    end
                end
            end
            ST_DIV:
            begin
                if (idx_reg < byte_cnt_reg)
                begin
                    msg_re    = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    div_ctrl.en = 1'b1;
                    msg_we      = 1'b1;
                    msg_waddr   = proc_idx[AW-1:0];
                    msg_wdata   = quo;
                    if (!seen_nz_reg)
                    begin
                        if (quo == 8'd0)
                        begin
                            nstart_next = idx_reg;
                        end
                        else
                        begin
                            seen_nz_next = 1'b1;
                        end
                    end
                    // end of one pass: remainder is the next digit
                    if (idx_reg == byte_cnt_reg)
                    begin
                        if (digit_cnt_reg < DCW'(MAX_CHARS))
                        begin
                            dig_we         = 1'b1;
                            digit_cnt_next = digit_cnt_reg + 1'b1;
                        end
                        div_ctrl.clr = 1'b1;
                        if (nstart_fin < byte_cnt_reg)
                        begin
                            idx_next     = nstart_fin;
                            nstart_next  = nstart_fin;
                            seen_nz_next = 1'b0;
                        end
                        else
                        begin
                            k_next     = '0;
                            state_next = ST_PREP;
                        end
                    end
                end
            end
            ST_PREP:
            begin
                dig_re     = (kr_ext >= TW'(zero_run_reg)) && (kr_ext < tot);
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                dig_re         = (kr_ext >= TW'(zero_run_reg)) && (kr_ext < tot);
                strobe_next    = 1'b1;
                out_char_next  = (TW'(k_reg) < TW'(zero_run_reg)) ? CHAR_ONE
                                                                  : b58_char(dig_rd_reg);
                if (TW'(k_reg) + 1'b1 == tot_cap)
                begin
                    last_char_next = 1'b1;
                    byte_cnt_next  = '0;
                    zero_run_next  = '0;
                    in_zero_next   = 1'b1;
                    ovf_seen_next  = 1'b0;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            byte_cnt_reg  <= '0;
            zero_run_reg  <= '0;
            in_zero_reg   <= 1'b1;
            ovf_seen_reg  <= 1'b0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            seen_nz_reg   <= 1'b0;
            nstart_reg    <= '0;
            digit_cnt_reg <= '0;
            k_reg         <= '0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            byte_cnt_reg  <= byte_cnt_next;
            zero_run_reg  <= zero_run_next;
            in_zero_reg   <= in_zero_next;
            ovf_seen_reg  <= ovf_seen_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            seen_nz_reg   <= seen_nz_next;
            nstart_reg    <= nstart_next;
            digit_cnt_reg <= digit_cnt_next;
            k_reg         <= k_next;
            strobe_reg    <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg  <= out_char_next;
        last_char_reg <= last_char_next;
        overflow_reg  <= overflow_next;
    end

    always_ff @(posedge clk)
    begin
        if (msg_we)
        begin
            msg_mem[msg_waddr] <= msg_wdata;
        end
        if (msg_re)
        begin
            msg_rd_reg <= msg_mem[idx_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dig_we)
        begin
            dig_mem[dig_waddr] <= rem;
        end
        if (dig_re)
        begin
            dig_rd_reg <= dig_mem[dig_raddr];
        end
    end

    assign strobe    = strobe_reg;
    assign out_char  = out_char_reg;
    assign last_char = last_char_reg;
    assign overflow  = overflow_reg;

`ifndef SYNTH
    a_ovf_result: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && overflow |-> last_char && out_char == 7'd0)
        else $error("overflow result carries a character or is not final");

    a_last_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && last_byte |=> busy || (strobe && overflow))
        else $error("final byte neither started encoding nor gave overflow");

    a_idle_strobe_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !busy |-> last_char)
        else $error("result shown while idle is not the final character");

    a_div_index: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> idx_reg <= byte_cnt_reg && nstart_reg < byte_cnt_reg)
        else $error("division pass index beyond message length");
`endif

endmodule

`default_nettype wire
